FILE: sv/grdwf_pkg.sv
package grdwf_pkg;

  localparam int CORDIC_STAGES = 24;

  // Datapath widths
  localparam int CW        = 33;  // rotation x/y/z
  localparam int VW        = 34;  // vectoring x/y
  localparam int VZW       = 33;  // vectoring z
  localparam int SQ_OUT_W  = 31;
  localparam int SQ_IN_W   = 2 * SQ_OUT_W;
  localparam int SQ_REM_W  = SQ_OUT_W + 4;

  // Angle conversion constants
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [31:0] DIV_FULL = 32'd1800000000;
  localparam logic [31:0] DIV_HALF = 32'd3600000000;
  localparam logic [63:0] RCP_FULL_W = (64'd3373259426 << 32) / 64'd1800000000;
  localparam logic [63:0] RCP_HALF_W = (64'd3373259426 << 32) / 64'd3600000000;
  localparam logic [32:0] RCP_FULL = RCP_FULL_W[32:0];
  localparam logic [32:0] RCP_HALF = RCP_HALF_W[32:0];

  localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30  = 33'sd1073741824;
  localparam logic [60:0]          ONE_Q60  = 61'h1000000000000000;

  localparam logic signed [30:0] LAT_LIMIT     = 31'sd900000000;
  localparam logic signed [33:0] LON_HALF_TURN = 34'sd1800000000;
  localparam logic signed [33:0] LON_TURN      = 34'sd3600000000;

  localparam logic [23:0] DIAMETER_M = 24'd12742000;
  localparam logic [24:0] DIST_CAP   = 25'd20015087;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // Unit latencies
  localparam int LAT_RAD = 4;
  localparam int LAT_ROT = CORDIC_STAGES + 1;
  localparam int LAT_VEC = CORDIC_STAGES;
  localparam int L_CORE  = 2 + LAT_RAD + LAT_ROT + 1 + SQ_OUT_W + 3 + SQ_OUT_W + LAT_VEC + 2;

  // Configuration register map
  typedef enum logic [2:0] {
    CFG_REF_LAT  = 3'd0,
    CFG_REF_LON  = 3'd1,
    CFG_REF_DAY  = 3'd2,
    CFG_DAYS_BACK = 3'd3,
    CFG_MAX_DIST = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] DAYS_BACK_RST = 16'd13;
  localparam logic [24:0] MAX_DIST_RST  = 25'd500000;

endpackage

FILE: sv/grdwf_rad.sv
// Angle magnitude in 1e-7 degree to Q1.30 radians (halved when half_i), rounded,
// by reciprocal multiply with a single correction step.
module grdwf_rad (
  input  logic               clk,
  input  logic               en,
  input  logic               half_i,
  input  logic signed [31:0] ang_i,
  output logic [30:0]        q_o
);

  logic [30:0] m_r;
  logic [62:0] mp_r;
  logic [63:0] mc_r;
  logic [63:0] n_r;
  logic [63:0] ed_r;
  logic [31:0] e0_r;
  logic [31:0] q_r;

  logic [31:0] dv;
  logic [32:0] rcp;
  logic [31:0] e0;
  logic [63:0] rem;
  logic [31:0] neg;

  assign dv  = half_i ? grdwf_pkg::DIV_HALF : grdwf_pkg::DIV_FULL;
  assign rcp = half_i ? grdwf_pkg::RCP_HALF : grdwf_pkg::RCP_FULL;
  assign neg = 32'(-ang_i);
  assign e0  = mc_r[63:32];
  assign rem = n_r - ed_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= ang_i[31] ? neg[30:0] : ang_i[30:0];
      mp_r <= 63'(m_r) * 63'(grdwf_pkg::PI_Q30);
      mc_r <= 64'(m_r) * 64'(rcp);
      n_r  <= 64'(mp_r) + 64'(dv >> 1);
      ed_r <= 64'(e0) * 64'(dv);
      e0_r <= e0;
      q_r  <= e0_r + 32'(rem >= 64'(dv));
    end
  end

  assign q_o = q_r[30:0];

endmodule

FILE: sv/grdwf_rot.sv
// Pipelined CORDIC rotation, one iteration per stage, clamped output.
module grdwf_rot (
  input  logic        clk,
  input  logic        en,
  input  logic        want_cos,
  input  logic [30:0] z_i,
  output logic [30:0] val_o
);

  localparam int N  = grdwf_pkg::CORDIC_STAGES;
  localparam int CW = grdwf_pkg::CW;

  logic signed [CW-1:0] x_r [N];
  logic signed [CW-1:0] y_r [N];
  logic signed [CW-1:0] z_r [N];
  logic [30:0]          val_r;

  function automatic logic [30:0] clamp_q30(input logic signed [CW-1:0] v);
    logic [30:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > grdwf_pkg::ONE_Q30) begin
      res = grdwf_pkg::ONE_Q30[30:0];
    end else begin
      res = v[30:0];
    end
    return res;
  endfunction

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [CW-1:0] ANG = {1'b0, grdwf_pkg::ATAN_TAB[i]};
    logic signed [CW-1:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = grdwf_pkg::GAIN_Q30;
      assign yi = '0;
      assign zi = $signed({2'b00, z_i});
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[CW-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ANG;
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ANG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= want_cos ? clamp_q30(x_r[N-1]) : clamp_q30(y_r[N-1]);
    end
  end

  assign val_o = val_r;

endmodule

FILE: sv/grdwf_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module grdwf_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [grdwf_pkg::SQ_IN_W-1:0]  rad_i,
  output logic [grdwf_pkg::SQ_OUT_W-1:0] root_o
);

  localparam int N  = grdwf_pkg::SQ_OUT_W;
  localparam int IW = grdwf_pkg::SQ_IN_W;
  localparam int W  = grdwf_pkg::SQ_REM_W;

  logic [W-1:0]  rem_r  [N-1];
  logic [N-1:0]  root_r [N];
  logic [IW-1:0] rest_r [N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W-1:0]  rem_p;
    logic [N-1:0]  root_p;
    logic [IW-1:0] rest_p;
    logic [W-1:0]  cur;
    logic [W-1:0]  trial;
    logic          fit;
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rest_p = rad_i;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rest_p = rest_r[k-1];
    end
    assign cur   = {rem_p[W-3:0], rest_p[IW-1 -: 2]};
    assign trial = {{(W-N-2){1'b0}}, root_p, 2'b01};
    assign fit   = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_p[N-2:0], fit};
      end
    end

    if (k < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= fit ? cur - trial : cur;
          rest_r[k] <= {rest_p[IW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_r[N-1];

endmodule

FILE: sv/grdwf_vec.sv
// Pipelined CORDIC vectoring: angle of (g, h), clamped at zero.
module grdwf_vec (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] h_i,
  input  logic [30:0] g_i,
  output logic [30:0] t_o
);

  localparam int N   = grdwf_pkg::CORDIC_STAGES;
  localparam int VW  = grdwf_pkg::VW;
  localparam int VZW = grdwf_pkg::VZW;

  logic signed [VW-1:0]  x_r [N];
  logic signed [VW-1:0]  y_r [N];
  logic signed [VZW-1:0] z_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [VZW-1:0] ANG = {1'b0, grdwf_pkg::ATAN_TAB[i]};
    logic signed [VW-1:0]  xi, yi;
    logic signed [VZW-1:0] zi;
    if (i == 0) begin : g_first
      assign xi = $signed({3'b000, g_i});
      assign yi = $signed({3'b000, h_i});
      assign zi = '0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[VW-1]) begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ANG;
        end else begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ANG;
        end
      end
    end
  end

  assign t_o = z_r[N-1][VZW-1] ? '0 : z_r[N-1][30:0];

endmodule

FILE: sv/geo_radius_day_window_filter.sv
// Channel   Dir  Word contents (lowest bit first)
// in_       in   tdata: rec_day[15:0], rec_lat[46:16], rec_lon[78:47], zero pad
// out_      out  tdata: distance_m[24:0], zero pad; tuser: keep
// cfg_      in   cfg_index selects the register, cfg_data carries the value
//
// One record per cycle while the output is not stalled; the latency from
// accept to out_tvalid is set by the 31-stage square root pipelines and
// the rotation and vectoring CORDIC pipelines.
// rst_n (synchronous) clears the valid bits and loads register defaults.
// The whole pipeline holds while a result word waits on out_tready.
module geo_radius_day_window_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // rec_day[15:0], rec_lat[46:16], rec_lon[78:47]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // distance_m[24:0]
  output logic        out_tuser,  // keep
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int L   = grdwf_pkg::L_CORE;
  localparam int SQW = grdwf_pkg::SQ_OUT_W;
  localparam int S2_DLY = SQW + 1;  // s2 waits for the first square root
  localparam int S1_DLY = SQW + 2;  // s1 waits one more for y

  // Configuration registers
  logic signed [30:0] ref_lat_r;
  logic signed [31:0] ref_lon_r;
  logic [15:0]        ref_day_r;
  logic [15:0]        days_back_r;
  logic [24:0]        max_dist_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r   <= '0;
      ref_lon_r   <= '0;
      ref_day_r   <= '0;
      days_back_r <= grdwf_pkg::DAYS_BACK_RST;
      max_dist_r  <= grdwf_pkg::MAX_DIST_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        grdwf_pkg::CFG_REF_LAT:   ref_lat_r   <= $signed(cfg_data[30:0]);
        grdwf_pkg::CFG_REF_LON:   ref_lon_r   <= $signed(cfg_data);
        grdwf_pkg::CFG_REF_DAY:   ref_day_r   <= cfg_data[15:0];
        grdwf_pkg::CFG_DAYS_BACK: days_back_r <= cfg_data[15:0];
        grdwf_pkg::CFG_MAX_DIST:  max_dist_r  <= cfg_data[24:0];
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  // Global advance: move every stage unless a finished word is stuck.
  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Valid bits and the day-window flag ride alongside the datapath.
  logic [L-1:0] vld_r;
  logic [L-1:0] win_r;
  logic [15:0]  rec_day;
  logic [15:0]  win_lo;
  logic         win_nxt;

  assign rec_day = in_tdata[15:0];
  assign win_lo  = (ref_day_r >= days_back_r) ? ref_day_r - days_back_r : '0;
  assign win_nxt = (rec_day <= ref_day_r) && (rec_day >= win_lo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_r <= {win_r[L-2:0], win_nxt};
    end
  end

  // Entry: saturate latitudes, take the raw longitude difference.
  function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] v);
    logic signed [30:0] res;
    if (v > grdwf_pkg::LAT_LIMIT) begin
      res = grdwf_pkg::LAT_LIMIT;
    end else if (v < -grdwf_pkg::LAT_LIMIT) begin
      res = -grdwf_pkg::LAT_LIMIT;
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic signed [30:0] lat1_r, lat2_r;
  logic signed [32:0] dlon_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      lat1_r <= clamp_lat(ref_lat_r);
      lat2_r <= clamp_lat($signed(in_tdata[46:16]));
      dlon_r <= 33'($signed(in_tdata[78:47])) - 33'(ref_lon_r);
    end
  end

  // Latitude difference and longitude wrap into one half turn either way.
  logic signed [31:0] dlat_r, dlonw_r, lat1e_r, lat2e_r;
  logic signed [33:0] dlon_x;
  logic signed [33:0] dlon_wrap;

  assign dlon_x = 34'(dlon_r);
  always_comb begin
    if (dlon_x > grdwf_pkg::LON_HALF_TURN) begin
      dlon_wrap = dlon_x - grdwf_pkg::LON_TURN;
    end else if (dlon_x < -grdwf_pkg::LON_HALF_TURN) begin
      dlon_wrap = dlon_x + grdwf_pkg::LON_TURN;
    end else begin
      dlon_wrap = dlon_x;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dlat_r  <= 32'(lat2_r) - 32'(lat1_r);
      dlonw_r <= dlon_wrap[31:0];
      lat1e_r <= 32'(lat1_r);
      lat2e_r <= 32'(lat2_r);
    end
  end

  // Angle conversion and sine/cosine lanes
  logic [30:0] q_dlat, q_dlon, q_lat1, q_lat2;
  logic [30:0] s1, s2, c1, c2;

  grdwf_rad u_rad_dlat (.clk, .en(adv), .half_i(1'b1), .ang_i(dlat_r),  .q_o(q_dlat));
  grdwf_rad u_rad_dlon (.clk, .en(adv), .half_i(1'b1), .ang_i(dlonw_r), .q_o(q_dlon));
  grdwf_rad u_rad_lat1 (.clk, .en(adv), .half_i(1'b0), .ang_i(lat1e_r), .q_o(q_lat1));
  grdwf_rad u_rad_lat2 (.clk, .en(adv), .half_i(1'b0), .ang_i(lat2e_r), .q_o(q_lat2));

  grdwf_rot u_rot_s1 (.clk, .en(adv), .want_cos(1'b0), .z_i(q_dlat), .val_o(s1));
  grdwf_rot u_rot_s2 (.clk, .en(adv), .want_cos(1'b0), .z_i(q_dlon), .val_o(s2));
  grdwf_rot u_rot_c1 (.clk, .en(adv), .want_cos(1'b1), .z_i(q_lat1), .val_o(c1));
  grdwf_rot u_rot_c2 (.clk, .en(adv), .want_cos(1'b1), .z_i(q_lat2), .val_o(c2));

  // Hold the sines until the cosine product has been rooted.
  logic [30:0] s1_dly_r [S1_DLY];
  logic [30:0] s2_dly_r [S2_DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dly_r[0] <= s1;
      s2_dly_r[0] <= s2;
      for (int k = 1; k < S1_DLY; k++) begin
        s1_dly_r[k] <= s1_dly_r[k-1];
      end
      for (int k = 1; k < S2_DLY; k++) begin
        s2_dly_r[k] <= s2_dly_r[k-1];
      end
    end
  end

  // cc = c1*c2 in Q30, then r = sqrt(cc)
  logic [61:0] cc_prod;
  logic [30:0] cc_r;
  logic [SQW-1:0] r_root;

  assign cc_prod = 62'(c1) * 62'(c2);
  always_ff @(posedge clk) begin
    if (adv) begin
      cc_r <= cc_prod[60:30];
    end
  end

  grdwf_isqrt u_sqrt_r (.clk, .en(adv), .rad_i({1'b0, cc_r, 30'b0}), .root_o(r_root));

  // y = r*s2, squares, haversine term a and its complement
  logic [61:0] y_prod;
  logic [30:0] y_r;
  logic [61:0] p1_r, p2_r;
  logic [62:0] a_sum;
  logic        a_big;
  logic [62:0] a_cmp;
  logic [60:0] a_r, na_r;

  assign y_prod = 62'(r_root) * 62'(s2_dly_r[S2_DLY-1]);
  assign a_sum  = 63'(p1_r) + 63'(p2_r);
  assign a_big  = a_sum >= 63'(grdwf_pkg::ONE_Q60);
  assign a_cmp  = 63'(grdwf_pkg::ONE_Q60) - a_sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      y_r  <= y_prod[60:30];
      p1_r <= 62'(s1_dly_r[S1_DLY-1]) * 62'(s1_dly_r[S1_DLY-1]);
      p2_r <= 62'(y_r) * 62'(y_r);
      a_r  <= a_big ? grdwf_pkg::ONE_Q60 : a_sum[60:0];
      na_r <= a_big ? '0 : a_cmp[60:0];
    end
  end

  logic [SQW-1:0] h_root, g_root;
  grdwf_isqrt u_sqrt_h (.clk, .en(adv), .rad_i({1'b0, a_r}),  .root_o(h_root));
  grdwf_isqrt u_sqrt_g (.clk, .en(adv), .rad_i({1'b0, na_r}), .root_o(g_root));

  // Half the central angle, then scale by the diameter with rounding and cap.
  logic [30:0] t_ang;
  logic [54:0] dist_prod_r;
  logic [55:0] dist_sum;
  logic [25:0] dist_full;
  logic [24:0] dist_r;

  grdwf_vec u_vec (.clk, .en(adv), .h_i(h_root), .g_i(g_root), .t_o(t_ang));

  assign dist_sum  = 56'(dist_prod_r) + 56'(1) * 56'(2**29);
  assign dist_full = dist_sum[55:30];

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_prod_r <= 55'(t_ang) * 55'(grdwf_pkg::DIAMETER_M);
      dist_r      <= (dist_full > 26'(grdwf_pkg::DIST_CAP)) ? grdwf_pkg::DIST_CAP
                                                             : dist_full[24:0];
    end
  end

  // Output register: the word waits here while the sink stalls.
  logic [24:0] out_dist_r;
  logic        out_keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dist_r <= dist_r;
      out_keep_r <= win_r[L-1] && (dist_r <= max_dist_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_dist_r};
  assign out_tuser  = out_keep_r;

`ifndef SYNTHESIS
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(vld_r))
    else $error("pipeline moved while output stalled");

  a_dist_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dist_r <= grdwf_pkg::DIST_CAP))
    else $error("distance above cap");

  a_keep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_keep_r) |-> (out_dist_r <= max_dist_r))
    else $error("keep set beyond threshold");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted word not tracked");
`endif

endmodule
